// File: hdl/frdr_pkg.sv
// Shared constants and types for the frame descriptor ring.
`default_nettype none
package frdr_pkg;

	// The ring depth must be a power of two: read index steps wrap by truncation.
	localparam int SLOT_COUNT   = 64;
	localparam int BUFFER_BYTES = 1048576;

	localparam int SLOT_W   = $clog2(SLOT_COUNT);
	localparam int WIDX_W   = SLOT_W + 1;
	localparam int OFFSET_W = 20;
	localparam int LEN_W    = 21;
	localparam int CFG_W    = 6;
	localparam int CFG_IDX_W = 1;
	localparam int SLOT_DATA_W = OFFSET_W + LEN_W;
	localparam int LAG_W    = ((WIDX_W > CFG_W) ? WIDX_W : CFG_W) + 1;
	localparam int ADD_W    = ((SLOT_W > CFG_W) ? SLOT_W : CFG_W) + 1;

	localparam logic [CFG_W-1:0] LAG_LIMIT_RESET = CFG_W'(10);
	localparam logic [CFG_W-1:0] SKIP_STEP_RESET = CFG_W'(9);

	localparam logic [CFG_IDX_W-1:0] CFG_LAG_LIMIT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_STEP = CFG_IDX_W'(1);

	localparam logic OP_PUT = 1'b0;
	localparam logic OP_GET = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic do_put;
		logic do_get;
		logic emit_get;
	} frdr_cmd_t;

endpackage
`default_nettype wire

// File: hdl/frdr_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module frdr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// File: hdl/frdr_ctrl.sv
// Controller: accepts commands and sequences the get through its read state.
`default_nettype none
module frdr_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             opcode,
	output logic                  busy,
	output frdr_pkg::frdr_cmd_t   cmd
);
	import frdr_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_GET_RD
	} state_t;

	state_t state_q;
	logic   accept;

	assign accept       = start && !busy;
	assign cmd.do_put   = accept && (opcode == OP_PUT);
	assign cmd.do_get   = accept && (opcode == OP_GET);
	assign cmd.emit_get = (state_q == ST_GET_RD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.do_get) begin
						state_q <= ST_GET_RD;
						busy    <= 1'b1;
					end
				end
				ST_GET_RD: begin
					state_q <= ST_IDLE;
					busy    <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy    <= 1'b0;
				end
			endcase
		end
	end

	// The slot read waits in the single state ST_GET_RD before the get returns to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_get |=> (state_q == ST_GET_RD) && busy)
		else $error("get did not enter the read state");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GET_RD) |=> (state_q == ST_IDLE) && !busy)
		else $error("read state lasted more than one cycle");
	assert property (@(posedge clk) disable iff (!arst_n)
		busy == (state_q == ST_GET_RD))
		else $error("busy out of step with state");
endmodule
`default_nettype wire

// File: hdl/frdr_dp.sv
// Datapath: config, indices, allocator, written bits, slot memory and result registers.
`default_nettype none
module frdr_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire frdr_pkg::frdr_cmd_t                 cmd,
	input  wire logic [frdr_pkg::LEN_W-1:0]          frame_length,
	input  wire logic                                advance,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [frdr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [frdr_pkg::CFG_W-1:0]          cfg_data,
	output logic                                     done,
	output logic                                     was_put,
	output logic                                     found,
	output logic [frdr_pkg::OFFSET_W-1:0]            byte_offset,
	output logic [frdr_pkg::LEN_W-1:0]               length_out
);
	import frdr_pkg::*;

	logic [CFG_W-1:0]      lag_limit_q;
	logic [CFG_W-1:0]      skip_step_q;
	logic [WIDX_W-1:0]     wi_q;
	logic [SLOT_W-1:0]     ri_q;
	logic [LEN_W-1:0]      fill_q;
	logic [SLOT_COUNT-1:0] written_q;
	logic                  hit_q;

	logic [LEN_W-1:0]       len_sat;
	logic [LEN_W:0]         fill_sum;
	logic                   restart;
	logic [LEN_W-1:0]       alloc;
	logic [SLOT_W-1:0]      put_slot;
	logic signed [LAG_W-1:0] lag;
	logic                   empty;
	logic                   over_limit;
	logic [ADD_W-1:0]       step_amt;
	logic [ADD_W-1:0]       ri_sum;
	logic [SLOT_DATA_W-1:0] ram_rdata;

	assign cfg_ready = 1'b1;

	// Put: saturate the length, then bump-allocate with restart at zero.
	always_comb begin
		len_sat  = (frame_length > LEN_W'(BUFFER_BYTES)) ? LEN_W'(BUFFER_BYTES) : frame_length;
		fill_sum = {1'b0, fill_q} + {1'b0, len_sat};
		restart  = (fill_q >= LEN_W'(BUFFER_BYTES)) || (fill_sum > (LEN_W + 1)'(BUFFER_BYTES));
		alloc    = restart ? '0 : fill_q;
		put_slot = (wi_q >= WIDX_W'(SLOT_COUNT)) ? '0 : wi_q[SLOT_W-1:0];
	end

	// Get: signed lag and the written bit decide availability; lag sets the size of the step.
	always_comb begin
		lag        = signed'(LAG_W'(wi_q)) - signed'(LAG_W'(ri_q));
		empty      = (lag == LAG_W'(0)) || (lag == LAG_W'(1)) || !written_q[ri_q];
		over_limit = lag > signed'(LAG_W'(lag_limit_q));
		step_amt   = over_limit ? ADD_W'(skip_step_q) : ADD_W'(1);
		ri_sum     = ADD_W'(ri_q) + step_amt;
	end

	frdr_ram #(
		.WIDTH(SLOT_DATA_W),
		.DEPTH(SLOT_COUNT)
	) u_slot_ram (
		.clk   (clk),
		.we    (cmd.do_put),
		.waddr (put_slot),
		.wdata ({alloc[OFFSET_W-1:0], len_sat}),
		.re    (cmd.do_get),
		.raddr (ri_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lag_limit_q <= LAG_LIMIT_RESET;
			skip_step_q <= SKIP_STEP_RESET;
			wi_q        <= '0;
			ri_q        <= '0;
			fill_q      <= '0;
			written_q   <= '0;
			hit_q       <= 1'b0;
			done        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LAG_LIMIT: lag_limit_q <= cfg_data;
					CFG_SKIP_STEP: skip_step_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.do_put) begin
				fill_q              <= alloc + len_sat;
				written_q[put_slot] <= 1'b1;
				wi_q                <= WIDX_W'(put_slot) + WIDX_W'(1);
			end
			if (cmd.do_get) begin
				hit_q <= !empty;
				if (!empty && advance) begin
					ri_q <= ri_sum[SLOT_W-1:0];
				end
			end
			done <= cmd.do_put || cmd.emit_get;
		end
	end

	// Result payload needs no reset; done qualifies it.
	always_ff @(posedge clk) begin
		if (cmd.do_put) begin
			was_put     <= 1'b1;
			found       <= 1'b1;
			byte_offset <= alloc[OFFSET_W-1:0];
			length_out  <= len_sat;
		end else if (cmd.emit_get) begin
			was_put     <= 1'b0;
			found       <= hit_q;
			byte_offset <= hit_q ? ram_rdata[SLOT_DATA_W-1:LEN_W] : '0;
			length_out  <= hit_q ? ram_rdata[LEN_W-1:0] : '0;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		wi_q <= WIDX_W'(SLOT_COUNT))
		else $error("write index beyond slot count");
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LEN_W'(BUFFER_BYTES))
		else $error("fill offset beyond buffer");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_put |=> written_q[$past(put_slot)])
		else $error("put left its slot unmarked");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.do_get && empty) |=> $stable(ri_q))
		else $error("read index moved on an empty get");
endmodule
`default_nettype wire

// File: hdl/frame_descriptor_ring_with_lag_skip.sv
// Top level of the frame descriptor ring with lag skip.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  command  | start / busy       | opcode, frame_length, advance
//  result   | done (one cycle)   | was_put, found, byte_offset, length_out
//  config   | cfg_valid/ready    | cfg_index, cfg_data
//
// A put's result appears on done in the cycle after it is taken, and puts may
// follow each other every cycle. A get reads the slot memory, whose read port
// is registered: busy is high in the controller's read state, which sets done.
// Reset clears the indices, fill offset, written bits, hit flag and done, and
// loads the config defaults; the slot memory and result payload hold no reset.
// The result receiver cannot stall, so the block never waits on it.
`default_nettype none
module frame_descriptor_ring_with_lag_skip (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic                           opcode,
	input  wire logic [frdr_pkg::LEN_W-1:0]     frame_length,
	input  wire logic                           advance,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [frdr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [frdr_pkg::CFG_W-1:0]     cfg_data,
	output logic                                done,
	output logic                                was_put,
	output logic                                found,
	output logic [frdr_pkg::OFFSET_W-1:0]       byte_offset,
	output logic [frdr_pkg::LEN_W-1:0]          length_out
);
	import frdr_pkg::*;

	frdr_cmd_t cmd;

	frdr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.busy   (busy),
		.cmd    (cmd)
	);

	frdr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.frame_length (frame_length),
		.advance      (advance),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.was_put      (was_put),
		.found        (found),
		.byte_offset  (byte_offset),
		.length_out   (length_out)
	);
endmodule
`default_nettype wire
